// ----- rtl/q4sd_pkg.sv -----
`default_nettype none
package q4sd_pkg;

  // Width of one exact Jacobian entry: 33-bit difference times 17-bit factor, summed.
  localparam int unsigned JW = 52;
  // Width of the exact determinant.
  localparam int unsigned DW = 104;
  // Width of the derivative numerators.
  localparam int unsigned NW = 72;
  // Scaled dividend: magnitude shifted by 32 plus half the divisor.
  localparam int unsigned SW = 106;
  // Quotient bits kept for saturation.
  localparam int unsigned QW = 34;

  // States of the back part.
  typedef enum logic [1:0] {ST_IDLE, ST_NUM, ST_DIV, ST_OUT} q4sd_state_e;

  // Request passed from the front part to the back part.
  typedef struct packed {
    logic               bad;
    logic signed [16:0] p;
    logic signed [16:0] q;
    logic signed [16:0] r;
    logic signed [16:0] s;
    logic signed [JW-1:0] j00;
    logic signed [JW-1:0] j01;
    logic signed [JW-1:0] j10;
    logic signed [JW-1:0] j11;
    logic signed [DW-1:0] det;
  } q4sd_req_t;

  // One result row.
  typedef struct packed {
    logic [1:0]  node_index;
    logic [14:0] shape_value;
    logic [31:0] dn_dx;
    logic [31:0] dn_dy;
    logic [63:0] jacobian_det;
    logic        bad_geometry;
    logic        last_row;
  } q4sd_row_t;

endpackage
`default_nettype wire

// ----- rtl/quad4_shape_derivatives_core.sv -----
`default_nettype none
// Bilinear four-node quadrilateral shape functions and global derivatives.
// Each pushed point yields four rows (nodes 0 to 3, last_row on node 3), or a
// single flagged row when the Jacobian determinant is zero or negative. A
// five-stage front pipeline forms the Jacobian and determinant and takes a
// point every cycle while it has room; a two-entry queue feeds the back part,
// where two bit-serial dividers produce dn_dx and dn_dy for one node. For each
// node the back part forms the numerators, loads the dividers, runs 106 quotient
// steps and emits the row; it takes the next point from the queue only after
// the last row of the current one, or of a flagged point, is emitted. The
// divider length sets the sustained rate; a row that is not popped holds the
// back part at its output stage.
module quad4_shape_derivatives_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic signed [15:0] xi_coord_i,
  input  wire logic signed [15:0] eta_coord_i,
  input  wire logic signed [31:0] node0_x_i,
  input  wire logic signed [31:0] node0_y_i,
  input  wire logic signed [31:0] node1_x_i,
  input  wire logic signed [31:0] node1_y_i,
  input  wire logic signed [31:0] node2_x_i,
  input  wire logic signed [31:0] node2_y_i,
  input  wire logic signed [31:0] node3_x_i,
  input  wire logic signed [31:0] node3_y_i,
  output logic                    empty,
  input  wire logic               pop,
  output logic [1:0]              node_index_o,
  output logic [14:0]             shape_value_o,
  output logic signed [31:0]      dn_dx_o,
  output logic signed [31:0]      dn_dy_o,
  output logic signed [63:0]      jacobian_det_o,
  output logic                    bad_geometry_o,
  output logic                    last_row_o
);
  logic in_ready, fv, fr, bv, br, rv;
  q4sd_pkg::q4sd_req_t freq, breq;
  q4sd_pkg::q4sd_row_t row;
  logic signed [31:0] xs [4];
  logic signed [31:0] ys [4];

  assign xs[0] = node0_x_i; assign xs[1] = node1_x_i;
  assign xs[2] = node2_x_i; assign xs[3] = node3_x_i;
  assign ys[0] = node0_y_i; assign ys[1] = node1_y_i;
  assign ys[2] = node2_y_i; assign ys[3] = node3_y_i;
  assign full = !in_ready;
  assign empty = !rv;

  q4sd_front u_front (
    .clk_i, .rst_ni, .in_valid_i(push), .in_ready_o(in_ready),
    .xi_i(xi_coord_i), .eta_i(eta_coord_i), .x_i(xs), .y_i(ys),
    .req_valid_o(fv), .req_ready_i(fr), .req_o(freq)
  );

  q4sd_queue u_queue (
    .clk_i, .rst_ni, .wr_valid_i(fv), .wr_ready_o(fr), .wr_data_i(freq),
    .rd_valid_o(bv), .rd_ready_i(br), .rd_data_o(breq)
  );

  q4sd_back u_back (
    .clk_i, .rst_ni, .req_valid_i(bv), .req_ready_o(br), .req_i(breq),
    .row_valid_o(rv), .row_ready_i(pop), .row_o(row)
  );

  assign node_index_o = row.node_index;
  assign shape_value_o = row.shape_value;
  assign dn_dx_o = row.dn_dx;
  assign dn_dy_o = row.dn_dy;
  assign jacobian_det_o = row.jacobian_det;
  assign bad_geometry_o = row.bad_geometry;
  assign last_row_o = row.last_row;
endmodule
`default_nettype wire

// ----- rtl/q4sd_front.sv -----
`default_nettype none
// Front part: forms the natural factors, the Jacobian and its determinant
// in a five-stage pipeline, and hands a request to the queue. The two
// determinant products are built from 26-bit pieces of the Jacobian entries.
module q4sd_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic signed [15:0]    xi_i,
  input  wire logic signed [15:0]    eta_i,
  input  wire logic signed [31:0]    x_i [4],
  input  wire logic signed [31:0]    y_i [4],
  output logic                       req_valid_o,
  input  wire logic                  req_ready_i,
  output q4sd_pkg::q4sd_req_t        req_o
);
  localparam int unsigned JW = q4sd_pkg::JW;
  localparam int unsigned DW = q4sd_pkg::DW;
  localparam int unsigned HW = JW / 2;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [16:0] p1_q, q1_q, r1_q, s1_q;
  logic signed [32:0] dx_q [4];
  logic signed [32:0] dy_q [4];
  logic signed [JW-1:0] j00_q, j01_q, j10_q, j11_q;
  logic signed [16:0] p2_q, q2_q, r2_q, s2_q;
  logic signed [JW-1:0] ma [2];
  logic signed [JW-1:0] mb [2];
  logic signed [2*HW-1:0] hh_q [2];
  logic signed [2*HW:0] hl_q [2];
  logic signed [2*HW:0] lh_q [2];
  logic [2*HW-1:0] ll_q [2];
  logic [DW-1:0] pp_q [2];
  logic signed [DW-1:0] det_c;
  q4sd_pkg::q4sd_req_t s2_c, c3_q, c4_q, s4_c, r5_q;
  logic stall;

  // The pipeline moves whenever its last stage is free or being drained.
  assign stall = v5_q && !req_ready_i;
  assign in_ready_o = !stall;
  assign req_valid_o = v5_q;
  assign req_o = r5_q;

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (!stall) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage one: factors and coordinate differences.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      p1_q <= 17'sd16384 - 17'(xi_i);
      q1_q <= 17'sd16384 + 17'(xi_i);
      r1_q <= 17'sd16384 - 17'(eta_i);
      s1_q <= 17'sd16384 + 17'(eta_i);
      dx_q[0] <= 33'(x_i[1]) - 33'(x_i[0]);
      dx_q[1] <= 33'(x_i[2]) - 33'(x_i[3]);
      dx_q[2] <= 33'(x_i[3]) - 33'(x_i[0]);
      dx_q[3] <= 33'(x_i[2]) - 33'(x_i[1]);
      dy_q[0] <= 33'(y_i[1]) - 33'(y_i[0]);
      dy_q[1] <= 33'(y_i[2]) - 33'(y_i[3]);
      dy_q[2] <= 33'(y_i[3]) - 33'(y_i[0]);
      dy_q[3] <= 33'(y_i[2]) - 33'(y_i[1]);
    end
  end

  // Stage two: Jacobian entries.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      j00_q <= JW'(dx_q[0] * r1_q) + JW'(dx_q[1] * s1_q);
      j01_q <= JW'(dx_q[2] * p1_q) + JW'(dx_q[3] * q1_q);
      j10_q <= JW'(dy_q[0] * r1_q) + JW'(dy_q[1] * s1_q);
      j11_q <= JW'(dy_q[2] * p1_q) + JW'(dy_q[3] * q1_q);
      p2_q <= p1_q;
      q2_q <= q1_q;
      r2_q <= r1_q;
      s2_q <= s1_q;
    end
  end

  // Request fields known after stage two.
  always_comb begin
    s2_c = '0;
    s2_c.p = p2_q;
    s2_c.q = q2_q;
    s2_c.r = r2_q;
    s2_c.s = s2_q;
    s2_c.j00 = j00_q;
    s2_c.j01 = j01_q;
    s2_c.j10 = j10_q;
    s2_c.j11 = j11_q;
  end

  // Operand pairs of the two determinant products.
  assign ma[0] = j00_q;
  assign mb[0] = j11_q;
  assign ma[1] = j01_q;
  assign mb[1] = j10_q;

  // Stage three: partial products of the high and low halves.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int k = 0; k < 2; k++) begin
        hh_q[k] <= $signed(ma[k][JW-1:HW]) * $signed(mb[k][JW-1:HW]);
        hl_q[k] <= $signed(ma[k][JW-1:HW]) * $signed({1'b0, mb[k][HW-1:0]});
        lh_q[k] <= $signed({1'b0, ma[k][HW-1:0]}) * $signed(mb[k][JW-1:HW]);
        ll_q[k] <= ma[k][HW-1:0] * mb[k][HW-1:0];
      end
      c3_q <= s2_c;
    end
  end

  // Stage four: the two full products.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      for (int k = 0; k < 2; k++) begin
        pp_q[k] <= (DW'(hh_q[k]) << (2 * HW)) + ((DW'(hl_q[k]) + DW'(lh_q[k])) << HW) +
                   DW'(ll_q[k]);
      end
      c4_q <= c3_q;
    end
  end

  // Determinant and its sign test.
  always_comb begin
    det_c = pp_q[0] - pp_q[1];
    s4_c = c4_q;
    s4_c.det = det_c;
    s4_c.bad = det_c[DW-1] || (det_c == '0);
  end

  // Stage five: the finished request.
  always_ff @(posedge clk_i) begin
    if (!stall) begin
      r5_q <= s4_c;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/q4sd_queue.sv -----
`default_nettype none
// Two-entry queue that lets the front and back parts stall on their own.
module q4sd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_valid_i,
  output logic                   wr_ready_o,
  input  wire q4sd_pkg::q4sd_req_t wr_data_i,
  output logic                   rd_valid_o,
  input  wire logic              rd_ready_i,
  output q4sd_pkg::q4sd_req_t    rd_data_o
);
  q4sd_pkg::q4sd_req_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// ----- rtl/q4sd_back.sv -----
`default_nettype none
// Back part: for each node forms the derivative numerators, divides them by
// the determinant with two radix-2 dividers and emits the row.
module q4sd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                req_valid_i,
  output logic                     req_ready_o,
  input  wire q4sd_pkg::q4sd_req_t req_i,
  output logic                     row_valid_o,
  input  wire logic                row_ready_i,
  output q4sd_pkg::q4sd_row_t      row_o
);
  localparam int unsigned SW = q4sd_pkg::SW;
  localparam int unsigned DW = q4sd_pkg::DW;
  localparam int unsigned NW_L = q4sd_pkg::NW;

  q4sd_pkg::q4sd_state_e st_q, st_d;

  q4sd_pkg::q4sd_req_t cur_q;
  logic [1:0] node_q;
  logic [6:0] cnt_q;
  logic nxneg_q, nyneg_q;
  logic [SW-1:0] nx_q, ny_q, rx_q, ry_q;
  logic [q4sd_pkg::QW-1:0] qx_q, qy_q;
  logic [q4sd_pkg::NW-1:0] a1_q, a2_q, b1_q, b2_q;
  logic signed [16:0] dxi, deta, fa, fb;
  q4sd_pkg::q4sd_row_t row_q;
  logic row_v_q;
  logic take, out_free;

  assign out_free = !row_v_q || row_ready_i;
  assign row_valid_o = row_v_q;
  assign row_o = row_q;
  assign req_ready_o = (st_q == q4sd_pkg::ST_IDLE);
  assign take = req_valid_i && req_ready_o;

  // Per-node factors.
  always_comb begin
    unique case (node_q)
      2'd0: begin dxi = -cur_q.r; deta = -cur_q.p; fa = cur_q.p; fb = cur_q.r; end
      2'd1: begin dxi =  cur_q.r; deta = -cur_q.q; fa = cur_q.q; fb = cur_q.r; end
      2'd2: begin dxi =  cur_q.s; deta =  cur_q.q; fa = cur_q.q; fb = cur_q.s; end
      default: begin dxi = -cur_q.s; deta = cur_q.p; fa = cur_q.p; fb = cur_q.s; end
    endcase
  end

  // Numerators from the registered products.
  logic signed [q4sd_pkg::NW-1:0] nx_c, ny_c;
  assign nx_c = a1_q - a2_q;
  assign ny_c = b1_q - b2_q;

  // Divider step: restoring, one quotient bit a cycle.
  logic [DW:0] dvs;
  logic [SW:0] tx, ty;
  assign dvs = {1'b0, cur_q.det};
  assign tx = {rx_q, nx_q[SW-1]};
  assign ty = {ry_q, ny_q[SW-1]};

  // Rounded, saturated determinant output.
  logic [DW-1:0] rd_c;
  logic [63:0] det_out;
  assign rd_c = cur_q.det + (DW'(1) << 31);
  assign det_out = (rd_c[DW-1:95] != '0) ? 64'h7FFF_FFFF_FFFF_FFFF : rd_c[95:32];

  // The top quotient bit is sticky, so any overflow still saturates.
  function automatic logic [31:0] sat_q(input logic neg, input logic [33:0] q);
    if (!neg) return (q > 34'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    return (q > 34'h8000_0000) ? 32'h8000_0000 : 32'(-q);
  endfunction

  logic signed [33:0] sh_p;
  logic [14:0] shape_c;
  assign sh_p = fa * fb;
  always_comb begin
    logic [33:0] t;
    t = 34'(sh_p) + 34'd32768;
    if (sh_p < 0) shape_c = '0;
    else if (t[33:16] > 18'd32767) shape_c = 15'h7FFF;
    else shape_c = t[30:16];
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= q4sd_pkg::ST_IDLE;
    else st_q <= st_d;
  end

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      q4sd_pkg::ST_IDLE: if (take) st_d = req_i.bad ? q4sd_pkg::ST_OUT : q4sd_pkg::ST_NUM;
      q4sd_pkg::ST_NUM:  st_d = q4sd_pkg::ST_DIV;
      q4sd_pkg::ST_DIV:  if (cnt_q == 7'd0) st_d = q4sd_pkg::ST_OUT;
      q4sd_pkg::ST_OUT:  if (out_free) begin
        st_d = (cur_q.bad || node_q == 2'd3) ? q4sd_pkg::ST_IDLE : q4sd_pkg::ST_NUM;
      end
      default: st_d = q4sd_pkg::ST_IDLE;
    endcase
  end

  // Output row register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_v_q <= 1'b0;
    else if (st_q == q4sd_pkg::ST_OUT && out_free) row_v_q <= 1'b1;
    else if (row_ready_i) row_v_q <= 1'b0;
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    logic [NW_L-1:0] mx, my;
    if (take) begin
      cur_q <= req_i;
      node_q <= 2'd0;
    end
    unique case (st_q)
      q4sd_pkg::ST_IDLE: ;
      q4sd_pkg::ST_NUM: begin
        a1_q <= q4sd_pkg::NW'(dxi * cur_q.j11);
        a2_q <= q4sd_pkg::NW'(deta * cur_q.j10);
        b1_q <= q4sd_pkg::NW'(deta * cur_q.j00);
        b2_q <= q4sd_pkg::NW'(dxi * cur_q.j01);
        cnt_q <= 7'(SW);
        rx_q <= '0;
        ry_q <= '0;
      end
      q4sd_pkg::ST_DIV: begin
        if (cnt_q == 7'(SW)) begin
          mx = nx_c[q4sd_pkg::NW-1] ? NW_L'(-nx_c) : NW_L'(nx_c);
          my = ny_c[q4sd_pkg::NW-1] ? NW_L'(-ny_c) : NW_L'(ny_c);
          nxneg_q <= nx_c[q4sd_pkg::NW-1];
          nyneg_q <= ny_c[q4sd_pkg::NW-1];
          nx_q <= (SW'(mx) << 32) + SW'(cur_q.det >> 1);
          ny_q <= (SW'(my) << 32) + SW'(cur_q.det >> 1);
        end else begin
          nx_q <= nx_q << 1;
          ny_q <= ny_q << 1;
          if (tx >= (SW+1)'(dvs)) begin
            rx_q <= SW'(tx - (SW+1)'(dvs));
            qx_q <= {qx_q[33] | qx_q[32], qx_q[31:0], 1'b1};
          end else begin
            rx_q <= SW'(tx);
            qx_q <= {qx_q[33] | qx_q[32], qx_q[31:0], 1'b0};
          end
          if (ty >= (SW+1)'(dvs)) begin
            ry_q <= SW'(ty - (SW+1)'(dvs));
            qy_q <= {qy_q[33] | qy_q[32], qy_q[31:0], 1'b1};
          end else begin
            ry_q <= SW'(ty);
            qy_q <= {qy_q[33] | qy_q[32], qy_q[31:0], 1'b0};
          end
        end
        if (cnt_q == 7'(SW)) begin
          qx_q <= '0; qy_q <= '0; cnt_q <= cnt_q - 7'd1;
        end else if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
      end
      q4sd_pkg::ST_OUT: if (out_free) begin
        if (cur_q.bad) begin
          row_q <= q4sd_pkg::q4sd_row_t'{bad_geometry: 1'b1, last_row: 1'b1, default: '0};
        end else begin
          row_q.node_index <= node_q;
          row_q.shape_value <= shape_c;
          row_q.dn_dx <= sat_q(nxneg_q, qx_q);
          row_q.dn_dy <= sat_q(nyneg_q, qy_q);
          row_q.jacobian_det <= det_out;
          row_q.bad_geometry <= 1'b0;
          row_q.last_row <= (node_q == 2'd3);
          node_q <= node_q + 2'd1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- sim/tb_quad4_shape_derivatives_core.sv -----
`timescale 1ns / 1ps

module tb_quad4_shape_derivatives_core;

  // One quadrilateral request: a natural point and four corners.
  typedef struct {
    logic signed [15:0] xi;
    logic signed [15:0] eta;
    logic signed [31:0] cx [4];
    logic signed [31:0] cy [4];
  } quad_point_t;

  // Directed row: the request and whether a single flagged row is known up front.
  typedef struct {
    quad_point_t pt;
    bit          flagged;
  } quad_case_t;

  localparam int N_RANDOM = 340;
  localparam int N_CALM   = 60;
  localparam logic signed [127:0] POS_LIMIT = 128'sd2147483647;
  localparam logic signed [127:0] NEG_LIMIT = 128'sd2147483648;
  localparam logic signed [127:0] DET_LIMIT = 128'sh7FFF_FFFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic signed [15:0] xi_coord_i = '0;
  logic signed [15:0] eta_coord_i = '0;
  logic signed [31:0] node0_x_i = '0;
  logic signed [31:0] node0_y_i = '0;
  logic signed [31:0] node1_x_i = '0;
  logic signed [31:0] node1_y_i = '0;
  logic signed [31:0] node2_x_i = '0;
  logic signed [31:0] node2_y_i = '0;
  logic signed [31:0] node3_x_i = '0;
  logic signed [31:0] node3_y_i = '0;
  logic [1:0]         node_index_o;
  logic [14:0]        shape_value_o;
  logic signed [31:0] dn_dx_o;
  logic signed [31:0] dn_dy_o;
  logic signed [63:0] jacobian_det_o;
  logic               bad_geometry_o;
  logic               last_row_o;

  q4sd_pkg::q4sd_row_t pending_rows[$];
  int        mismatches = 0;
  bit        calm = 1'b0;

  quad4_shape_derivatives_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full),
    .xi_coord_i(xi_coord_i), .eta_coord_i(eta_coord_i),
    .node0_x_i(node0_x_i), .node0_y_i(node0_y_i),
    .node1_x_i(node1_x_i), .node1_y_i(node1_y_i),
    .node2_x_i(node2_x_i), .node2_y_i(node2_y_i),
    .node3_x_i(node3_x_i), .node3_y_i(node3_y_i),
    .empty(empty), .pop(pop),
    .node_index_o(node_index_o), .shape_value_o(shape_value_o),
    .dn_dx_o(dn_dx_o), .dn_dy_o(dn_dy_o), .jacobian_det_o(jacobian_det_o),
    .bad_geometry_o(bad_geometry_o), .last_row_o(last_row_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Quotient of a derivative numerator by the determinant, rounded half away
  // from zero and saturated to Q16.16.
  function automatic logic [31:0] global_slope(logic signed [127:0] num,
                                               logic signed [127:0] det);
    logic signed [127:0] mag;
    logic signed [127:0] quot;
    logic signed [127:0] negq;
    mag  = (num < 0) ? -num : num;
    quot = ((mag <<< 32) + (det >>> 1)) / det;
    negq = -quot;
    if (num >= 0) begin
      return (quot > POS_LIMIT) ? 32'h7FFF_FFFF : quot[31:0];
    end
    return (quot > NEG_LIMIT) ? 32'h8000_0000 : negq[31:0];
  endfunction

  // Shape value from two Q14 factors, rounded half up and clamped.
  function automatic logic [14:0] shape_weight(longint fa, longint fb);
    longint v;
    v = fa * fb;
    if (v < 0) begin
      return '0;
    end
    v = (v + 32768) >>> 16;
    return (v > 32767) ? 15'h7FFF : v[14:0];
  endfunction

  // Works out the rows one request produces and queues them.
  function automatic void queue_node_rows(quad_point_t pt);
    longint xi, eta, p, q, r, s, j00, j01, j10, j11;
    longint x [4];
    longint y [4];
    longint dxi [4];
    longint deta [4];
    longint fa [4];
    longint fb [4];
    logic signed [127:0] a00, a01, a10, a11, det, rd, nx, ny, c, d;
    logic [63:0] det_out;
    q4sd_pkg::q4sd_row_t row;
    xi = pt.xi;
    eta = pt.eta;
    for (int k = 0; k < 4; k++) begin
      x[k] = pt.cx[k];
      y[k] = pt.cy[k];
    end
    p = 16384 - xi;
    q = 16384 + xi;
    r = 16384 - eta;
    s = 16384 + eta;
    j00 = (x[1] - x[0]) * r + (x[2] - x[3]) * s;
    j01 = (x[3] - x[0]) * p + (x[2] - x[1]) * q;
    j10 = (y[1] - y[0]) * r + (y[2] - y[3]) * s;
    j11 = (y[3] - y[0]) * p + (y[2] - y[1]) * q;
    a00 = j00;
    a01 = j01;
    a10 = j10;
    a11 = j11;
    det = a00 * a11 - a01 * a10;
    row = '0;
    if (det <= 0) begin
      row.bad_geometry = 1'b1;
      row.last_row = 1'b1;
      pending_rows.push_back(row);
      return;
    end
    rd = (det + 128'sh8000_0000) >>> 32;
    det_out = (rd > DET_LIMIT) ? 64'h7FFF_FFFF_FFFF_FFFF : rd[63:0];
    dxi = '{-r, r, s, -s};
    deta = '{-p, -q, q, p};
    fa = '{p, q, q, p};
    fb = '{r, r, s, s};
    for (int k = 0; k < 4; k++) begin
      c = dxi[k];
      d = deta[k];
      nx = c * a11 - d * a10;
      ny = d * a00 - c * a01;
      row.node_index = k[1:0];
      row.shape_value = shape_weight(fa[k], fb[k]);
      row.dn_dx = global_slope(nx, det);
      row.dn_dy = global_slope(ny, det);
      row.jacobian_det = det_out;
      row.bad_geometry = 1'b0;
      row.last_row = (k == 3);
      pending_rows.push_back(row);
    end
  endfunction

  function automatic quad_point_t make_quad(int xi, int eta, int x0, int y0, int x1,
                                            int y1, int x2, int y2, int x3, int y3);
    quad_point_t pt;
    pt.xi = xi[15:0];
    pt.eta = eta[15:0];
    pt.cx = '{x0, x1, x2, x3};
    pt.cy = '{y0, y1, y2, y3};
    return pt;
  endfunction

  // Drives one request and waits until it is accepted.
  task automatic send_quad(quad_point_t pt, bit flagged);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      push = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    xi_coord_i = pt.xi;
    eta_coord_i = pt.eta;
    node0_x_i = pt.cx[0]; node0_y_i = pt.cy[0];
    node1_x_i = pt.cx[1]; node1_y_i = pt.cy[1];
    node2_x_i = pt.cx[2]; node2_y_i = pt.cy[2];
    node3_x_i = pt.cx[3]; node3_y_i = pt.cy[3];
    push = 1'b1;
    do @(posedge clk_i); while (full);
    if (flagged) begin
      pending_rows.push_back(q4sd_pkg::q4sd_row_t'{bad_geometry: 1'b1, last_row: 1'b1,
                                                   default: '0});
    end else begin
      queue_node_rows(pt);
    end
  endtask

  // Mostly a perturbed square of random size and position, sometimes raw noise.
  function automatic quad_point_t random_quad();
    quad_point_t pt;
    int sc, ox, oy, j;
    if ($urandom_range(0, 5) == 0) begin
      pt.xi = 16'($urandom());
      pt.eta = 16'($urandom());
      for (int k = 0; k < 4; k++) begin
        pt.cx[k] = $urandom();
        pt.cy[k] = $urandom();
      end
      return pt;
    end
    pt.xi = 16'($urandom_range(0, 32768) - 16384);
    pt.eta = 16'($urandom_range(0, 32768) - 16384);
    sc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32'h3FFF_FFFF)
                                     : $urandom_range(1, 32'h00FF_FFFF);
    ox = $urandom_range(0, 32'h3FFF_FFFF) - 32'sh2000_0000;
    oy = $urandom_range(0, 32'h3FFF_FFFF) - 32'sh2000_0000;
    j = sc / 4 + 1;
    pt.cx = '{ox, ox + sc, ox + sc, ox};
    pt.cy = '{oy, oy, oy + sc, oy + sc};
    for (int k = 0; k < 4; k++) begin
      pt.cx[k] += $urandom_range(0, j) - j / 2;
      pt.cy[k] += $urandom_range(0, j) - j / 2;
    end
    if ($urandom_range(0, 9) == 0) begin
      pt.cx = '{pt.cx[3], pt.cx[2], pt.cx[1], pt.cx[0]};
      pt.cy = '{pt.cy[3], pt.cy[2], pt.cy[1], pt.cy[0]};
    end
    return pt;
  endfunction

  // Result side: random pop stalls, each accepted row compared with the oldest one due.
  initial begin
    int stall;
    q4sd_pkg::q4sd_row_t due;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        stall--;
        pop = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(0, 13);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        if (pending_rows.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected row: node %0d bad %0b", node_index_o, bad_geometry_o);
          end
        end else begin
          due = pending_rows.pop_front();
          if (node_index_o !== due.node_index || shape_value_o !== due.shape_value ||
              dn_dx_o !== due.dn_dx || dn_dy_o !== due.dn_dy ||
              jacobian_det_o !== due.jacobian_det ||
              bad_geometry_o !== due.bad_geometry || last_row_o !== due.last_row) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch: expected idx %0d N %0d dx %h dy %h det %h bad %0b last %0b",
                       due.node_index, due.shape_value, due.dn_dx, due.dn_dy,
                       due.jacobian_det, due.bad_geometry, due.last_row);
              $display("              actual   idx %0d N %0d dx %h dy %h det %h bad %0b last %0b",
                       node_index_o, shape_value_o, dn_dx_o, dn_dy_o, jacobian_det_o,
                       bad_geometry_o, last_row_o);
            end
          end
        end
      end
    end
  end

  // Stimulus: directed table, a full drain, then random requests.
  initial begin
    quad_case_t cases[$];
    int one;
    one = 32'sh0001_0000;
    // Unit square at the centre, the corners and outside the natural range.
    cases.push_back('{make_quad(0, 0, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(-16384, -16384, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(16384, 16384, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(16384, -16384, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(-32768, 32767, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(32767, -32768, 0, 0, one, 0, one, one, 0, one), 1'b0});
    cases.push_back('{make_quad(-1, 1, -one, -one, one, -one, one, one, -one, one), 1'b0});
    // Tiny element: derivatives saturate high and low.
    cases.push_back('{make_quad(0, 0, 0, 0, 1, 0, 1, 1, 0, 1), 1'b0});
    cases.push_back('{make_quad(8192, -8192, 5, 5, 6, 5, 6, 6, 5, 6), 1'b0});
    // Huge element: corners at the limits of the coordinate range, very large determinant.
    cases.push_back('{make_quad(0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                32'sh8000_0000, 32'sh7FFF_FFFF), 1'b0});
    cases.push_back('{make_quad(12345, -9876, 32'sh8000_0000, 0, 0, 32'sh8000_0000,
                                32'sh7FFF_FFFF, 0, 0, 32'sh7FFF_FFFF), 1'b0});
    // Bad geometry: collapsed, clockwise and zero determinant.
    cases.push_back('{make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1});
    cases.push_back('{make_quad(0, 0, 0, 0, 0, one, one, one, one, 0), 1'b1});
    cases.push_back('{make_quad(16384, 16384, 0, 0, one, 0, 2 * one, 0, 3 * one, 0), 1'b1});
    cases.push_back('{make_quad(-16384, 0, -one, -one, -one, -one, -one, -one, -one, -one),
                      1'b1});
    // Skewed and trapezoidal shapes.
    cases.push_back('{make_quad(4096, 12000, 0, 0, 3 * one, one, 2 * one, 4 * one, -one, 2 * one),
                      1'b0});
    cases.push_back('{make_quad(-7000, 3000, 100, -200, one, 7, one / 2, one, 9, one / 3),
                      1'b0});

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (cases[i]) begin
      send_quad(cases[i].pt, cases[i].flagged);
    end
    // Hold the sender off until everything so far has drained.
    @(negedge clk_i);
    push = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk_i);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) begin
        calm = 1'b1;
      end
      send_quad(random_quad(), 1'b0);
    end
    @(negedge clk_i);
    push = 1'b0;

    while (pending_rows.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (mismatches == 0 && pending_rows.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- quad4_shape_derivatives_core.f -----
rtl/q4sd_pkg.sv
rtl/q4sd_front.sv
rtl/q4sd_queue.sv
rtl/q4sd_back.sv
rtl/quad4_shape_derivatives_core.sv
sim/tb_quad4_shape_derivatives_core.sv
